// ----- src/servo_status_packet_deframer_assert.svh -----
// ----------------------------------------------------------------------------
// Servo status packet deframer: assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_DEFRAMER_ASSERT_SVH
`define SERVO_STATUS_PACKET_DEFRAMER_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SSD_ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ssd_pkg.sv -----
// ----------------------------------------------------------------------------
// Servo status packet deframer package
// Shared types, codes and constants of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ssd_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // Final status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_LENGTH  = 3'd2;
    localparam logic [2:0] ST_BADID   = 3'd3;
    localparam logic [2:0] ST_CSUM    = 3'd4;

    // Result kinds.
    localparam logic KIND_PARAM  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] HDR_BYTE        = 8'hFF;
    localparam logic [7:0] MIN_LENGTH      = 8'd2;
    localparam logic [7:0] BROADCAST_RESET = 8'd254;

    // Default depth of each of the two internal queues.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } cmd_kind_t;

    // A classified request passed from the front to the back.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic       result_kind;
        logic [7:0] param_byte;
        logic [7:0] param_index;
        logic [2:0] status_code;
        logic [7:0] servo_error;
        logic       last;
    } result_t;

    // Queue status passed between modules.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_HUNT   = 8'b0000_0010,
        PH_HUNTFF = 8'b0000_0100,
        PH_ID     = 8'b0000_1000,
        PH_LEN    = 8'b0001_0000,
        PH_ERR    = 8'b0010_0000,
        PH_PARAM  = 8'b0100_0000,
        PH_CSUM   = 8'b1000_0000
    } phase_t;

endpackage

`default_nettype wire

// ----- src/ssd_fifo.sv -----
// ----------------------------------------------------------------------------
// Servo status packet deframer: small queue
// Register-based first-in first-out queue of generic width and depth.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output      logic [WIDTH-1:0] rd_data,
    output      ssd_pkg::queue_status_t status
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CntW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/ssd_front.sv -----
// ----------------------------------------------------------------------------
// Servo status packet deframer: front end
// Takes input requests, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module ssd_front #(
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output      logic         full,
    input  wire logic [1:0]   opcode,
    input  wire logic [7:0]   expected_id,
    input  wire logic [7:0]   rx_byte,
    input  wire logic         cmd_pop,
    output      ssd_pkg::cmd_t cmd,
    output      logic         cmd_valid
);

    ssd_pkg::cmd_t          cmd_in;
    logic                   cmd_push;
    logic                   known_op;
    ssd_pkg::queue_status_t q_status;

    // Unused opcodes are accepted but never reach the parser.
    always_comb
    begin
        known_op    = 1'b1;
        cmd_in.kind = ssd_pkg::CMD_BYTE;
        cmd_in.data = rx_byte;
        case (opcode)
            ssd_pkg::OP_START:
            begin
                cmd_in.kind = ssd_pkg::CMD_START;
                cmd_in.data = expected_id;
            end
            ssd_pkg::OP_BYTE:
            begin
                cmd_in.kind = ssd_pkg::CMD_BYTE;
            end
            ssd_pkg::OP_TIMEOUT:
            begin
                cmd_in.kind = ssd_pkg::CMD_TIMEOUT;
            end
            default:
            begin
                known_op = 1'b0;
            end
        endcase
    end

    assign cmd_push  = push && known_op;
    assign full      = q_status.full;
    assign cmd_valid = !q_status.empty;

    ssd_fifo #(
        .WIDTH ($bits(ssd_pkg::cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .pop     (cmd_pop),
        .rd_data (cmd),
        .status  (q_status)
    );

endmodule

`default_nettype wire

// ----- src/ssd_back.sv -----
// ----------------------------------------------------------------------------
// Servo status packet deframer: parser back end
// Packet state machine that turns requests into queued result items.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_status_packet_deframer_assert.svh"

module ssd_back #(
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      no_reply_id,
    input  wire ssd_pkg::cmd_t   cmd,
    input  wire logic            cmd_valid,
    output      logic            cmd_pop,
    input  wire logic            pop,
    output      logic            empty,
    output      ssd_pkg::result_t res_out
);

    ssd_pkg::phase_t        phase_reg, phase_next;
    logic [7:0]             awaited_id_reg, awaited_id_next;
    logic                   seen_reg, seen_next;
    logic [7:0]             bytes_left_reg, bytes_left_next;
    logic [7:0]             param_count_reg, param_count_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             held_error_reg, held_error_next;

    ssd_pkg::result_t       res;
    ssd_pkg::queue_status_t res_status;
    logic                   go;
    logic                   res_push;

    // Every request yields at most one result, so one free slot is enough.
    assign go      = cmd_valid && !res_status.full;
    assign cmd_pop = go;
    assign empty   = res_status.empty;

    always_comb
    begin
        phase_next       = phase_reg;
        awaited_id_next  = awaited_id_reg;
        seen_next        = seen_reg;
        bytes_left_next  = bytes_left_reg;
        param_count_next = param_count_reg;
        sum_next         = sum_reg;
        held_error_next  = held_error_reg;
        res_push         = 1'b0;
        res              = '0;

        if (go)
        begin
            case (cmd.kind)
                ssd_pkg::CMD_START:
                begin
                    if (phase_reg == ssd_pkg::PH_IDLE)
                    begin
                        if (cmd.data == no_reply_id)
                        begin
                            res_push        = 1'b1;
                            res.result_kind = ssd_pkg::KIND_STATUS;
                            res.status_code = ssd_pkg::ST_OK;
                            res.last        = 1'b1;
                        end
                        else
                        begin
                            phase_next       = ssd_pkg::PH_HUNT;
                            awaited_id_next  = cmd.data;
                            seen_next        = 1'b0;
                            bytes_left_next  = '0;
                            param_count_next = '0;
                            sum_next         = '0;
                            held_error_next  = '0;
                        end
                    end
                end
                ssd_pkg::CMD_TIMEOUT:
                begin
                    if (phase_reg != ssd_pkg::PH_IDLE)
                    begin
                        res_push        = 1'b1;
                        res.result_kind = ssd_pkg::KIND_STATUS;
                        res.status_code = seen_reg ? ssd_pkg::ST_LENGTH : ssd_pkg::ST_TIMEOUT;
                        res.last        = 1'b1;
                        phase_next      = ssd_pkg::PH_IDLE;
                    end
                end
                ssd_pkg::CMD_BYTE:
                begin
                    if (phase_reg != ssd_pkg::PH_IDLE)
                    begin
                        seen_next = 1'b1;
                        case (phase_reg)
                            ssd_pkg::PH_HUNT:
                            begin
                                if (cmd.data == ssd_pkg::HDR_BYTE)
                                begin
                                    phase_next = ssd_pkg::PH_HUNTFF;
                                end
                            end
                            ssd_pkg::PH_HUNTFF:
                            begin
                                phase_next = (cmd.data == ssd_pkg::HDR_BYTE) ?
                                             ssd_pkg::PH_ID : ssd_pkg::PH_HUNT;
                            end
                            ssd_pkg::PH_ID:
                            begin
                                if (cmd.data != awaited_id_reg)
                                begin
                                    res_push        = 1'b1;
                                    res.result_kind = ssd_pkg::KIND_STATUS;
                                    res.status_code = ssd_pkg::ST_BADID;
                                    res.last        = 1'b1;
                                    phase_next      = ssd_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    sum_next   = cmd.data;
                                    phase_next = ssd_pkg::PH_LEN;
                                end
                            end
                            ssd_pkg::PH_LEN:
                            begin
                                if (cmd.data < ssd_pkg::MIN_LENGTH)
                                begin
                                    res_push        = 1'b1;
                                    res.result_kind = ssd_pkg::KIND_STATUS;
                                    res.status_code = ssd_pkg::ST_LENGTH;
                                    res.last        = 1'b1;
                                    phase_next      = ssd_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    sum_next         = sum_reg + cmd.data;
                                    bytes_left_next  = cmd.data - ssd_pkg::MIN_LENGTH;
                                    param_count_next = '0;
                                    phase_next       = ssd_pkg::PH_ERR;
                                end
                            end
                            ssd_pkg::PH_ERR:
                            begin
                                held_error_next = cmd.data;
                                sum_next        = sum_reg + cmd.data;
                                phase_next      = (bytes_left_reg == '0) ?
                                                  ssd_pkg::PH_CSUM : ssd_pkg::PH_PARAM;
                            end
                            ssd_pkg::PH_PARAM:
                            begin
                                sum_next         = sum_reg + cmd.data;
                                res_push         = 1'b1;
                                res.result_kind  = ssd_pkg::KIND_PARAM;
                                res.param_byte   = cmd.data;
                                res.param_index  = param_count_reg;
                                param_count_next = param_count_reg + 8'd1;
                                bytes_left_next  = bytes_left_reg - 8'd1;
                                if (bytes_left_reg == 8'd1)
                                begin
                                    phase_next = ssd_pkg::PH_CSUM;
                                end
                            end
                            ssd_pkg::PH_CSUM:
                            begin
                                res_push        = 1'b1;
                                res.result_kind = ssd_pkg::KIND_STATUS;
                                res.last        = 1'b1;
                                phase_next      = ssd_pkg::PH_IDLE;
                                if (~sum_reg == cmd.data)
                                begin
                                    res.status_code = ssd_pkg::ST_OK;
                                    res.servo_error = held_error_reg;
                                end
                                else
                                begin
                                    res.status_code = ssd_pkg::ST_CSUM;
                                end
                            end
                            default:
                            begin
                                phase_next = ssd_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ssd_pkg::PH_IDLE;
            awaited_id_reg  <= '0;
            seen_reg        <= 1'b0;
            bytes_left_reg  <= '0;
            param_count_reg <= '0;
            sum_reg         <= '0;
            held_error_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            awaited_id_reg  <= awaited_id_next;
            seen_reg        <= seen_next;
            bytes_left_reg  <= bytes_left_next;
            param_count_reg <= param_count_next;
            sum_reg         <= sum_next;
            held_error_reg  <= held_error_next;
        end
    end

    ssd_fifo #(
        .WIDTH ($bits(ssd_pkg::result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .pop     (pop),
        .rd_data (res_out),
        .status  (res_status)
    );

    // A status item always closes the transaction.
    `SSD_ASSERT_NEXT(a_status_ends_packet, clk, rst_n, res_push && res.last, phase_reg == ssd_pkg::PH_IDLE, "status item did not return the parser to idle")
    // The parameter phase is only ever entered with bytes still to come.
    `SSD_ASSERT_HOLDS(a_param_has_bytes, clk, rst_n, (phase_reg == ssd_pkg::PH_PARAM) |-> (bytes_left_reg != 8'd0), "parameter phase with no bytes left")
    // Each parameter byte advances the parameter index by exactly one.
    `SSD_ASSERT_NEXT(a_param_index_steps, clk, rst_n, go && (cmd.kind == ssd_pkg::CMD_BYTE) && (phase_reg == ssd_pkg::PH_PARAM), param_count_reg == $past(param_count_reg) + 8'd1, "parameter index did not advance by one")

endmodule

`default_nettype wire

// ----- src/servo_status_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// Servo status packet deframer
// Hunts for a servo status packet in a byte stream and reports its contents.
// ----------------------------------------------------------------------------
// Usage. Requests enter through a queue-like port: a request is taken at a
// rising edge with push high and full low. A start request names the servo
// addressed, a byte request carries one received bus byte and a timeout
// request closes a transaction whose reply never came. Results leave through
// a second queue-like port: while empty is low the oldest result is on the
// result ports, and it is taken at an edge with pop high. Parameter bytes
// come out as they arrive; every transaction ends with one status item.
// The broadcast id is written through cfg_wr_en and cfg_wr_data while idle.
// A request is written into the request queue at the edge it is taken; the
// parser takes it at a later edge and queues its result.
// Throughput is one request per cycle while the result queue has room.
// If the receiver stops popping, the result queue and then the request
// queue fill, and full rises until results are drained again.
// Reset empties both queues, returns the parser to idle and sets the
// broadcast id to 254.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_deframer #(
    parameter int QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output      logic       full,
    input  wire logic [1:0] opcode,
    input  wire logic [7:0] expected_id,
    input  wire logic [7:0] rx_byte,
    output      logic       empty,
    input  wire logic       pop,
    output      logic       result_kind,
    output      logic [7:0] param_byte,
    output      logic [7:0] param_index,
    output      logic [2:0] status_code,
    output      logic [7:0] servo_error,
    output      logic       last,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data
);

    logic [7:0]       no_reply_id_reg, no_reply_id_next;
    ssd_pkg::cmd_t    cmd;
    logic             cmd_valid;
    logic             cmd_pop;
    ssd_pkg::result_t res_out;

    // The broadcast id register; changing it is only legal between packets.
    assign no_reply_id_next = cfg_wr_en ? cfg_wr_data : no_reply_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_reply_id_reg <= ssd_pkg::BROADCAST_RESET;
        end
        else
        begin
            no_reply_id_reg <= no_reply_id_next;
        end
    end

    // The front end classifies requests and buffers them for the parser.
    ssd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .expected_id (expected_id),
        .rx_byte     (rx_byte),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid)
    );

    // The back end runs the packet state machine and buffers its results.
    ssd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .no_reply_id  (no_reply_id_reg),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_pop      (cmd_pop),
        .pop          (pop),
        .empty        (empty),
        .res_out      (res_out)
    );

    assign result_kind = res_out.result_kind;
    assign param_byte  = res_out.param_byte;
    assign param_index = res_out.param_index;
    assign status_code = res_out.status_code;
    assign servo_error = res_out.servo_error;
    assign last        = res_out.last;

endmodule

`default_nettype wire
